// ===== rtl/core/frp_pkg.sv =====
// Shared types, codes and helpers for the frame replay filter.
package frp_pkg;

  localparam int NODE_W = 16;
  localparam int SEQ_W  = 8;
  localparam int TIME_W = 32;

  localparam logic [1:0] REQ_CLASSIFY = 2'd0;
  localparam logic [1:0] REQ_REMEMBER = 2'd1;
  localparam logic [1:0] REQ_CLEAR    = 2'd2;

  localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
  localparam logic [1:0] VERDICT_DUPLICATE = 2'd1;
  localparam logic [1:0] VERDICT_EXPIRED   = 2'd2;
  localparam logic [1:0] VERDICT_ORDER     = 2'd3;

  localparam logic [1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [1:0] CFG_ORDERED     = 2'd1;
  localparam logic [1:0] CFG_MAX_AGE     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // search token moving down the ring cells
  typedef struct packed {
    logic vld;
    logic hit;
  } ring_tok_t;

  // search token moving down the node table cells
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [SEQ_W-1:0] last;
  } node_tok_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] node;
    logic [SEQ_W-1:0]  seq;
  } ring_wr_t;

  typedef struct packed {
    logic              en;
    logic              node_en;
    logic [NODE_W-1:0] node;
    logic [SEQ_W-1:0]  last;
  } node_wr_t;

  // a is after b when (a - b) mod 256 lies in 1..127
  function automatic logic serial_after(input logic [SEQ_W-1:0] a,
                                        input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[SEQ_W-1];
  endfunction

endpackage

// ===== rtl/core/frp_ring_cell.sv =====
// One ring entry: holds a node and sequence pair and checks the passing search token.
module frp_ring_cell #(
  parameter int WINDOW_MAX = 32,
  parameter int IDX        = 0
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  frp_pkg::ring_tok_t                                      tok_in,
  output frp_pkg::ring_tok_t                                      tok_out,
  input  logic [frp_pkg::NODE_W-1:0]                              key_node,
  input  logic [frp_pkg::SEQ_W-1:0]                               key_seq,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]                         fill,
  input  frp_pkg::ring_wr_t                                       wr,
  input  logic [((WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1)-1:0]  wr_pos
);
  import frp_pkg::*;

  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [NODE_W-1:0] ent_node;
  logic [SEQ_W-1:0]  ent_seq;
  logic              match;

  assign match = tok_in.vld && (FW'(IDX) < fill) &&
                 (ent_node == key_node) && (ent_seq == key_seq);

  always_ff @(posedge clk) begin
    if (wr.en && (wr_pos == PW'(IDX))) begin
      ent_node <= wr.node;
      ent_seq  <= wr.seq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.hit <= tok_in.hit | match;
  end

endmodule

// ===== rtl/core/frp_node_cell.sv =====
// One node table slot: holds a node and its last sequence, first match claims the token.
module frp_node_cell #(
  parameter int NODES_MAX = 16,
  parameter int IDX       = 0
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  frp_pkg::node_tok_t                                    tok_in,
  input  logic [((NODES_MAX > 1) ? $clog2(NODES_MAX) : 1)-1:0]  slot_in,
  output frp_pkg::node_tok_t                                    tok_out,
  output logic [((NODES_MAX > 1) ? $clog2(NODES_MAX) : 1)-1:0]  slot_out,
  input  logic [frp_pkg::NODE_W-1:0]                            key_node,
  input  logic [$clog2(NODES_MAX+1)-1:0]                        fill,
  input  frp_pkg::node_wr_t                                     wr,
  input  logic [((NODES_MAX > 1) ? $clog2(NODES_MAX) : 1)-1:0]  wr_slot
);
  import frp_pkg::*;

  localparam int FW = $clog2(NODES_MAX + 1);
  localparam int NW = (NODES_MAX > 1) ? $clog2(NODES_MAX) : 1;

  logic [NODE_W-1:0] ent_node;
  logic [SEQ_W-1:0]  ent_last;
  logic              hit;

  assign hit = tok_in.vld && !tok_in.found && (FW'(IDX) < fill) &&
               (ent_node == key_node);

  always_ff @(posedge clk) begin
    if (wr.en && (wr_slot == NW'(IDX))) begin
      if (wr.node_en) begin
        ent_node <= wr.node;
      end
      ent_last <= wr.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.found <= tok_in.found | hit;
    tok_out.last  <= hit ? ent_last : tok_in.last;
    slot_out      <= hit ? NW'(IDX) : slot_in;
  end

endmodule

// ===== rtl/core/frame_replay_filter.sv =====
// Top level of the frame replay filter: sequencer, registers and the two cell chains.
//
// Requests come in on the req channel (valid/ready): classify, remember or clear.
// Every request gives exactly one verdict item on the res channel (valid/ready).
// Configuration writes use the cfg channel; cfg_ready is always high and
// writes are expected only while no request is in flight.
// A request is taken only when the sequencer is idle. Its search token then
// walks the ring cells and the node table cells, one cell per cycle. The scan
// lasts until the longer of the two chains is through; then the verdict
// register is loaded, and the next request can be taken the cycle after.
// The verdict sits in an output register; a new request is taken while it
// waits, but that request does not finish until the previous verdict leaves.
// Reset empties the ring and the node table (counts only) and loads the
// register defaults: window 32, unordered transport, age check off.
module frame_replay_filter #(
  parameter int WINDOW_MAX = 32,
  parameter int NODES_MAX  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [1:0]                   req_type,
  input  logic [frp_pkg::NODE_W-1:0]   node_id,
  input  logic [frp_pkg::SEQ_W-1:0]    seq,
  input  logic                         has_stamp,
  input  logic [frp_pkg::TIME_W-1:0]   stamp_s,
  input  logic [frp_pkg::TIME_W-1:0]   now_s,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [1:0]                   verdict,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [frp_pkg::TIME_W-1:0]   cfg_data
);
  import frp_pkg::*;

  localparam int WCW      = $clog2(WINDOW_MAX + 1);
  localparam int WPW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW       = (WCW > 6) ? WCW : 6;
  localparam int NCW      = $clog2(NODES_MAX + 1);
  localparam int NW       = (NODES_MAX > 1) ? $clog2(NODES_MAX) : 1;
  localparam int SCAN_LEN = ((WINDOW_MAX > NODES_MAX) ? WINDOW_MAX : NODES_MAX) + 1;
  localparam int SCW      = $clog2(SCAN_LEN + 1);

  state_t state, state_next;
  logic [SCW-1:0] cnt;
  logic           launch;
  logic           done_go;

  logic [1:0]        q_req;
  logic [NODE_W-1:0] q_node;
  logic [SEQ_W-1:0]  q_seq;
  logic              q_has;
  logic [TIME_W-1:0] q_stamp;
  logic [TIME_W-1:0] q_now;
  logic [TIME_W-1:0] age;
  logic [CW-1:0]     rem;

  logic              ring_hit;
  logic              node_found;
  logic [SEQ_W-1:0]  node_last;
  logic [NW-1:0]     node_slot;

  logic [WPW-1:0]    ring_write_pos;
  logic [WCW-1:0]    ring_fill;
  logic [NCW-1:0]    table_fill;

  logic [5:0]        window_size;
  logic              ordered_transport;
  logic [TIME_W-1:0] max_age;

  logic [CW-1:0]     win;
  logic [CW-1:0]     win_raw;
  logic              expired;
  logic [1:0]        verdict_next;
  logic              rem_go;

  ring_wr_t      ring_wr;
  node_wr_t      node_wr;
  logic [NW-1:0] node_wr_slot;

  ring_tok_t     rtok  [WINDOW_MAX+1];
  node_tok_t     ntok  [NODES_MAX+1];
  logic [NW-1:0] nslot [NODES_MAX+1];

  assign cfg_ready = 1'b1;

  // effective window: 0 acts as 1, clamp at WINDOW_MAX
  assign win_raw = CW'(window_size);
  assign win = (window_size == '0) ? CW'(1) :
               ((win_raw > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : win_raw);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    done_go    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt == SCW'(SCAN_LEN - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_valid || res_ready) begin
          done_go    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      launch <= 1'b0;
    end else begin
      launch <= req_valid && req_ready;
      if (state == ST_SCAN) begin
        cnt <= cnt + SCW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // ---------------- request capture and scan-time work ----------------
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      q_req   <= req_type;
      q_node  <= node_id;
      q_seq   <= seq;
      q_has   <= has_stamp;
      q_stamp <= stamp_s;
      q_now   <= now_s;
      rem     <= CW'(ring_write_pos) + CW'(1);
    end else if (state == ST_SCAN) begin
      // next write position: (pos + 1) mod window, one subtract per cycle
      if (rem >= win) rem <= rem - win;
    end
    // future stamps count as age zero
    age <= (q_now > q_stamp) ? (q_now - q_stamp) : '0;
    if (rtok[WINDOW_MAX].vld) ring_hit <= rtok[WINDOW_MAX].hit;
    if (ntok[NODES_MAX].vld) begin
      node_found <= ntok[NODES_MAX].found;
      node_last  <= ntok[NODES_MAX].last;
      node_slot  <= nslot[NODES_MAX];
    end
  end

  // ---------------- cell chains ----------------
  assign rtok[0].vld = launch;
  assign rtok[0].hit = 1'b0;

  assign ntok[0].vld   = launch;
  assign ntok[0].found = 1'b0;
  assign ntok[0].last  = '0;
  assign nslot[0]      = '0;

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_ring
      frp_ring_cell #(
        .WINDOW_MAX (WINDOW_MAX),
        .IDX        (gi)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .tok_in   (rtok[gi]),
        .tok_out  (rtok[gi+1]),
        .key_node (q_node),
        .key_seq  (q_seq),
        .fill     (ring_fill),
        .wr       (ring_wr),
        .wr_pos   (ring_write_pos)
      );
    end
    for (gi = 0; gi < NODES_MAX; gi++) begin : g_node
      frp_node_cell #(
        .NODES_MAX (NODES_MAX),
        .IDX       (gi)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .tok_in   (ntok[gi]),
        .slot_in  (nslot[gi]),
        .tok_out  (ntok[gi+1]),
        .slot_out (nslot[gi+1]),
        .key_node (q_node),
        .fill     (table_fill),
        .wr       (node_wr),
        .wr_slot  (node_wr_slot)
      );
    end
  endgenerate

  // ---------------- verdict and table updates ----------------
  assign expired = q_has && (max_age != '0) && (age > max_age);

  always_comb begin
    verdict_next = VERDICT_ACCEPT;
    if (q_req == REQ_CLASSIFY) begin
      priority if (ring_hit) begin
        verdict_next = VERDICT_DUPLICATE;
      end else if (expired) begin
        verdict_next = VERDICT_EXPIRED;
      end else if (!ordered_transport && node_found && !serial_after(q_seq, node_last)) begin
        verdict_next = VERDICT_ORDER;
      end else begin
        verdict_next = VERDICT_ACCEPT;
      end
    end
  end

  assign rem_go = done_go && (q_req == REQ_REMEMBER);

  assign ring_wr.en   = rem_go;
  assign ring_wr.node = q_node;
  assign ring_wr.seq  = q_seq;

  always_comb begin
    node_wr.node = q_node;
    node_wr.last = q_seq;
    if (node_found) begin
      // known node: last sequence only moves forward
      node_wr.en      = rem_go && serial_after(q_seq, node_last);
      node_wr.node_en = 1'b0;
      node_wr_slot    = node_slot;
    end else begin
      // new node: next free slot, or slot 0 once the table is full
      node_wr.en      = rem_go;
      node_wr.node_en = 1'b1;
      node_wr_slot    = (table_fill < NCW'(NODES_MAX)) ? table_fill[NW-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_write_pos <= '0;
      ring_fill      <= '0;
      table_fill     <= '0;
    end else if (done_go) begin
      unique case (q_req)
        REQ_REMEMBER: begin
          ring_write_pos <= rem[WPW-1:0];
          if (CW'(ring_fill) < win) ring_fill <= ring_fill + WCW'(1);
          if (!node_found && (table_fill < NCW'(NODES_MAX))) begin
            table_fill <= table_fill + NCW'(1);
          end
        end
        REQ_CLEAR: begin
          ring_write_pos <= '0;
          ring_fill      <= '0;
          table_fill     <= '0;
        end
        default: ;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done_go) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) verdict <= verdict_next;
  end

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size       <= 6'd32;
      ordered_transport <= 1'b0;
      max_age           <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE: window_size       <= cfg_data[5:0];
        CFG_ORDERED:     ordered_transport <= cfg_data[0];
        CFG_MAX_AGE:     max_age           <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- assertions ----------------
  ap_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (ring_fill <= WCW'(WINDOW_MAX)) && (table_fill <= NCW'(NODES_MAX)))
    else $error("fill count beyond table size");

  ap_pos_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> (rem < win))
    else $error("write position not reduced by end of scan");

  ap_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (done_go && (q_req == REQ_CLEAR)) |=>
      ((ring_fill == '0) && (table_fill == '0) && (ring_write_pos == '0)))
    else $error("clear item left entries live");

  ap_verdict_kind: assert property (@(posedge clk) disable iff (rst)
    (done_go && (q_req != REQ_CLASSIFY)) |=> (res_valid && (verdict == VERDICT_ACCEPT)))
    else $error("non-classify item gave a nonzero verdict");

endmodule

// ===== dv/frame_replay_filter_checker.sv =====
`timescale 1ns / 1ps
// Checker for the frame replay filter: tracks registers, predicts verdicts, compares results.
module frame_replay_filter_checker #(
  parameter int WINDOW_MAX = 32,
  parameter int NODES_MAX  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  logic [1:0]                 req_type,
  input  logic [frp_pkg::NODE_W-1:0] node_id,
  input  logic [frp_pkg::SEQ_W-1:0]  seq,
  input  logic                       has_stamp,
  input  logic [frp_pkg::TIME_W-1:0] stamp_s,
  input  logic [frp_pkg::TIME_W-1:0] now_s,
  input  logic                       res_valid,
  input  logic                       res_ready,
  input  logic [1:0]                 verdict,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [frp_pkg::TIME_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         pending
);
  import frp_pkg::*;

  logic [NODE_W-1:0] ring_node [WINDOW_MAX];
  logic [SEQ_W-1:0]  ring_seq  [WINDOW_MAX];
  int unsigned       ring_pos;
  int unsigned       ring_used;
  logic [NODE_W-1:0] peer_node [NODES_MAX];
  logic [SEQ_W-1:0]  peer_last [NODES_MAX];
  int unsigned       peer_count;

  logic [5:0]        window_reg;
  logic              ordered_reg;
  logic [TIME_W-1:0] age_limit;

  logic [1:0]        verdict_q [$];
  logic [1:0]        want;

  function automatic int unsigned window_span();
    if (window_reg == 6'd0) return 1;
    if (window_reg > WINDOW_MAX) return WINDOW_MAX;
    return 32'(window_reg);
  endfunction

  // serial order over 8 bits: forward distance 1..127
  function automatic logic seq_newer(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return (d != '0) && (d < 8'd128);
  endfunction

  function automatic int unsigned peer_slot(input logic [NODE_W-1:0] node);
    int unsigned i;
    for (i = 0; i < peer_count && i < NODES_MAX; i++)
      if (peer_node[i] == node) return i;
    return NODES_MAX;
  endfunction

  function automatic logic [1:0] judge_frame(input logic [NODE_W-1:0] node,
                                             input logic [SEQ_W-1:0] sq,
                                             input logic has,
                                             input logic [TIME_W-1:0] stamp,
                                             input logic [TIME_W-1:0] now);
    int unsigned       i;
    int unsigned       slot;
    logic [TIME_W-1:0] age;
    for (i = 0; i < ring_used && i < WINDOW_MAX; i++)
      if (ring_node[i] == node && ring_seq[i] == sq) return VERDICT_DUPLICATE;
    // a stamp from the future has age zero
    age = (now > stamp) ? now - stamp : '0;
    if (has && age_limit != '0 && age > age_limit) return VERDICT_EXPIRED;
    if (!ordered_reg) begin
      slot = peer_slot(node);
      if (slot < NODES_MAX && !seq_newer(sq, peer_last[slot])) return VERDICT_ORDER;
    end
    return VERDICT_ACCEPT;
  endfunction

  function automatic void record_pair(input logic [NODE_W-1:0] node,
                                      input logic [SEQ_W-1:0] sq);
    int unsigned span;
    int unsigned pos;
    int unsigned slot;
    span = window_span();
    pos = ring_pos % WINDOW_MAX;
    ring_node[pos] = node;
    ring_seq[pos] = sq;
    ring_pos = (pos + 1) % span;
    if (ring_used < span) ring_used++;
    slot = peer_slot(node);
    if (slot < NODES_MAX) begin
      if (seq_newer(sq, peer_last[slot])) peer_last[slot] = sq;
    end else begin
      // new node: next free slot, or slot 0 once the table is full
      if (peer_count < NODES_MAX) begin
        slot = peer_count;
        peer_count++;
      end else begin
        slot = 0;
      end
      peer_node[slot] = node;
      peer_last[slot] = sq;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      window_reg = 6'd32;
      ordered_reg = 1'b0;
      age_limit = '0;
      ring_pos = 0;
      ring_used = 0;
      peer_count = 0;
      verdict_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW_SIZE: window_reg = cfg_data[5:0];
          CFG_ORDERED:     ordered_reg = cfg_data[0];
          CFG_MAX_AGE:     age_limit = cfg_data;
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (verdict_q.size() == 0) begin
          $error("verdict: unexpected item, actual %0d", verdict);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (verdict !== want) begin
            $error("verdict: expected %0d, actual %0d", want, verdict);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        case (req_type)
          REQ_CLASSIFY: verdict_q.push_back(judge_frame(node_id, seq, has_stamp, stamp_s, now_s));
          REQ_REMEMBER: begin
            record_pair(node_id, seq);
            verdict_q.push_back(VERDICT_ACCEPT);
          end
          REQ_CLEAR: begin
            ring_pos = 0;
            ring_used = 0;
            peer_count = 0;
            verdict_q.push_back(VERDICT_ACCEPT);
          end
          default: verdict_q.push_back(VERDICT_ACCEPT);
        endcase
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ===== dv/frame_replay_filter_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the frame replay filter: clock, reset, stimulus and final verdict.
module frame_replay_filter_tb;
  import frp_pkg::*;

  localparam int WINDOW_MAX  = 32;
  localparam int NODES_MAX   = 16;
  localparam int POOL        = 22;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  logic [1:0]        req_type = REQ_CLASSIFY;
  logic [NODE_W-1:0] node_id = '0;
  logic [SEQ_W-1:0]  seq = '0;
  logic              has_stamp = 1'b0;
  logic [TIME_W-1:0] stamp_s = '0;
  logic [TIME_W-1:0] now_s = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  logic [1:0]        verdict;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_WINDOW_SIZE;
  logic [TIME_W-1:0] cfg_data = '0;

  int                fail_count;
  int                pending;

  bit                idle_on = 1'b1;
  bit                hold_go = 1'b0;
  logic [TIME_W-1:0] clock_s;
  logic [TIME_W-1:0] age_lim = '0;
  logic [NODE_W-1:0] pool_node [POOL];
  logic [SEQ_W-1:0]  pool_seq [POOL];
  logic [23:0]       replay_q [$];   // {node, seq} of recently remembered frames

  frame_replay_filter #(.WINDOW_MAX(WINDOW_MAX), .NODES_MAX(NODES_MAX)) uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
    .node_id(node_id), .seq(seq), .has_stamp(has_stamp),
    .stamp_s(stamp_s), .now_s(now_s),
    .res_valid(res_valid), .res_ready(res_ready), .verdict(verdict),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  frame_replay_filter_checker #(.WINDOW_MAX(WINDOW_MAX), .NODES_MAX(NODES_MAX)) chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
    .node_id(node_id), .seq(seq), .has_stamp(has_stamp),
    .stamp_s(stamp_s), .now_s(now_s),
    .res_valid(res_valid), .res_ready(res_ready), .verdict(verdict),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        res_ready <= 1'b0;
        hold_left--;
      end else begin
        res_ready <= !(idle_on && $urandom_range(0, 99) < 14);
      end
    end
  end

  task automatic send_frame(input logic [1:0] kind, input logic [NODE_W-1:0] node,
                            input logic [SEQ_W-1:0] sq, input logic has,
                            input logic [TIME_W-1:0] stamp, input logic [TIME_W-1:0] now);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 14) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    node_id <= node;
    seq <= sq;
    has_stamp <= has;
    stamp_s <= stamp;
    now_s <= now;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [TIME_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [TIME_W-1:0] win, input logic ord,
                            input logic [TIME_W-1:0] age);
    drain();
    write_reg(CFG_WINDOW_SIZE, win);
    write_reg(CFG_ORDERED, {31'd0, ord});
    write_reg(CFG_MAX_AGE, age);
    age_lim = age;
  endtask

  function automatic logic [SEQ_W-1:0] next_seq(input logic [SEQ_W-1:0] last);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return last + SEQ_W'($urandom_range(1, 3));
    if (r < 78) return last;
    if (r < 86) return last - SEQ_W'($urandom_range(1, 20));
    if (r < 90) return last + 8'd128;
    if (r < 95) return last + SEQ_W'($urandom_range(100, 140));
    return SEQ_W'($urandom);
  endfunction

  // ages cluster around the limit so both sides of it are hit
  task automatic make_stamp(output logic has, output logic [TIME_W-1:0] stamp,
                            output logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] age;
    clock_s = clock_s + $urandom_range(0, 3);
    now = clock_s;
    has = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 7))
      0: age = age_lim;
      1: age = age_lim + 1;
      2: age = age_lim - 1;
      3: age = 32'd0 - $urandom_range(1, 1000);
      4: age = $urandom;
      default: age = $urandom_range(0, age_lim);
    endcase
    stamp = now - age;
  endtask

  task automatic run_traffic(input int n);
    int                sent;
    int                r;
    int                k;
    logic [1:0]        kind;
    logic [SEQ_W-1:0]  sq;
    logic              has;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] now;
    sent = 0;
    clock_s = $urandom;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        kind = 2'($urandom_range(0, 3));
        send_frame(kind, NODE_W'($urandom), SEQ_W'($urandom), 1'($urandom),
                   $urandom, $urandom);
        if (kind != REQ_UNUSED) sent++;
      end else if (r < 8) begin
        send_frame(REQ_CLEAR, NODE_W'($urandom), SEQ_W'($urandom), 1'($urandom),
                   $urandom, $urandom);
        sent++;
      end else if (r < 16 && replay_q.size() > 0) begin
        k = $urandom_range(0, replay_q.size() - 1);
        make_stamp(has, stamp, now);
        send_frame(REQ_CLASSIFY, replay_q[k][23:8], replay_q[k][7:0], has, stamp, now);
        sent++;
      end else begin
        k = $urandom_range(0, POOL - 1);
        sq = next_seq(pool_seq[k]);
        make_stamp(has, stamp, now);
        send_frame(REQ_CLASSIFY, pool_node[k], sq, has, stamp, now);
        sent++;
        if ($urandom_range(0, 99) < 80) begin
          send_frame(REQ_REMEMBER, pool_node[k], sq, has, stamp, now);
          sent++;
          pool_seq[k] = sq;
          replay_q.push_back({pool_node[k], sq});
          if (replay_q.size() > 48) void'(replay_q.pop_front());
        end
      end
    end
  endtask

  initial begin : stimulus
    int i;
    int ph;
    pool_node[0] = '0;
    pool_node[1] = '1;
    pool_seq[0] = SEQ_W'($urandom);
    pool_seq[1] = SEQ_W'($urandom);
    for (i = 2; i < POOL; i++) begin
      pool_node[i] = NODE_W'($urandom);
      pool_seq[i] = SEQ_W'($urandom);
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // write every ring entry once so later window growth never exposes unwritten cells
    for (i = 0; i < WINDOW_MAX; i++)
      send_frame(REQ_REMEMBER, NODE_W'($urandom), SEQ_W'($urandom), 1'b0, '0, '0);

    send_frame(REQ_CLEAR, '0, '0, 1'b0, '0, '0);
    send_frame(REQ_CLASSIFY, 16'h0000, 8'h00, 1'b0, '0, '0);
    send_frame(REQ_REMEMBER, 16'h0000, 8'h00, 1'b0, '0, '0);
    send_frame(REQ_CLASSIFY, 16'h0000, 8'h00, 1'b0, '0, '0);
    send_frame(REQ_CLASSIFY, 16'h0000, 8'h01, 1'b0, '0, '0);
    send_frame(REQ_CLASSIFY, 16'h0000, 8'h80, 1'b0, '0, '0);  // half-circle distance
    send_frame(REQ_CLASSIFY, 16'h0000, 8'h7F, 1'b0, '0, '0);
    send_frame(REQ_REMEMBER, 16'hFFFF, 8'hFF, 1'b1, '1, '1);
    send_frame(REQ_CLASSIFY, 16'hFFFF, 8'h00, 1'b0, '0, '0);  // wraps past 255
    send_frame(REQ_CLASSIFY, 16'hFFFF, 8'hFE, 1'b0, '0, '0);
    send_frame(REQ_UNUSED, '1, '1, 1'b1, '1, '1);
    send_frame(REQ_CLASSIFY, 16'hFFFF, 8'hFF, 1'b0, '0, '0);
    drain();
    write_reg(CFG_MAX_AGE, 32'd10);
    send_frame(REQ_CLASSIFY, 16'h0005, 8'h00, 1'b1, 32'd90, 32'd100);
    send_frame(REQ_CLASSIFY, 16'h0005, 8'h00, 1'b1, 32'd89, 32'd100);
    send_frame(REQ_CLASSIFY, 16'h0005, 8'h00, 1'b1, 32'd200, 32'd100);  // future stamp
    send_frame(REQ_CLASSIFY, 16'h0005, 8'h00, 1'b0, '0, '1);
    send_frame(REQ_CLASSIFY, 16'h0005, 8'h00, 1'b1, '0, '1);
    send_frame(REQ_CLASSIFY, 16'hFFFF, 8'hFF, 1'b1, '0, '1);  // duplicate beats expired
    send_frame(REQ_CLASSIFY, 16'h0000, 8'h80, 1'b1, '0, '1);  // expired beats order
    drain();
    write_reg(CFG_MAX_AGE, '1);
    send_frame(REQ_CLASSIFY, 16'h0005, 8'h00, 1'b1, '0, '1);
    drain();
    write_reg(CFG_ORDERED, 32'd1);
    send_frame(REQ_CLASSIFY, 16'h0000, 8'h80, 1'b0, '0, '0);
    set_config(32'd1, 1'b0, '0);
    send_frame(REQ_REMEMBER, 16'h0001, 8'h0A, 1'b0, '0, '0);
    send_frame(REQ_REMEMBER, 16'h0002, 8'h14, 1'b0, '0, '0);
    send_frame(REQ_CLEAR, '1, '1, 1'b1, '1, '1);
    send_frame(REQ_CLASSIFY, 16'h0000, 8'h00, 1'b0, '0, '0);

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(32'd32, 1'b0, 32'd100);
        1: set_config(32'd1, 1'b0, '0);
        2: set_config(32'd0, 1'b1, '1);
        3: set_config(32'd63, 1'b0, 32'd1);
        4: set_config(32'd4, 1'b0, $urandom_range(1, 5000));
        5: set_config($urandom_range(0, 63), 1'($urandom_range(0, 1)), $urandom);
        6: set_config(32'd32, 1'b1, 32'd50);
        default: set_config($urandom_range(1, 32), 1'b0, $urandom_range(0, 200));
      endcase
      idle_on = (ph != 3);
      if (ph == 4) hold_go = 1'b1;
      run_traffic((ph == 3) ? 120 : 85);
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== frame_replay_filter.f =====
rtl/core/frp_pkg.sv
rtl/core/frp_ring_cell.sv
rtl/core/frp_node_cell.sv
rtl/core/frame_replay_filter.sv
dv/frame_replay_filter_checker.sv
dv/frame_replay_filter_tb.sv
